// ===== hw/rtl/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg
// shared types, codes and transfer table for the character lcd sequencer
// ----------------------------------------------------------------------------
package lcdseq_pkg;

    localparam int LINE_WIDTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 4;

    // job kinds handed from front to back
    localparam logic [2:0] KIND_INIT   = 3'd0;
    localparam logic [2:0] KIND_CLEAR  = 3'd1;
    localparam logic [2:0] KIND_SETPOS = 3'd2;
    localparam logic [2:0] KIND_DIRECT = 3'd3;
    localparam logic [2:0] KIND_LINE2  = 3'd4;
    localparam logic [2:0] KIND_SCROLL = 3'd5;

    // input actions
    localparam logic [1:0] ACT_INIT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_SETPOS = 2'd2;
    localparam logic [1:0] ACT_CHAR   = 2'd3;

    // lcd commands
    localparam logic [7:0] CMD_FUNC_SET  = 8'h3C;
    localparam logic [7:0] CMD_DISP_CTRL = 8'h0F;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_SHIFT     = 8'h18;
    localparam logic [7:0] LINE1_BASE    = 8'h80;
    localparam logic [7:0] LINE2_BASE    = 8'hC0;

    localparam logic [10:0] WAIT_SHORT = 11'd40;
    localparam logic [10:0] WAIT_LONG  = 11'd1800;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] addr;      // line offset, or full address for set position
        logic [7:0] old_char;
        logic [7:0] new_char;
    } job_t;

    typedef struct packed {
        logic [7:0]  bus_byte;
        logic        is_data;
        logic [10:0] wait_time;
        logic        last;
    } xfer_t;

    function automatic xfer_t make_xfer(input job_t job, input logic [2:0] step);
        xfer_t x;
        x.bus_byte  = CMD_CLEAR;
        x.is_data   = 1'b0;
        x.wait_time = WAIT_SHORT;
        x.last      = 1'b1;
        unique case (job.kind)
            KIND_INIT:
            begin
                x.last = (step == 3'd3);
                unique case (step)
                    3'd0:    x.bus_byte = CMD_FUNC_SET;
                    3'd1:    x.bus_byte = CMD_DISP_CTRL;
                    3'd2:
                    begin
                        x.bus_byte  = CMD_CLEAR;
                        x.wait_time = WAIT_LONG;
                    end
                    default: x.bus_byte = CMD_ENTRY;
                endcase
            end
            KIND_CLEAR:
            begin
                x.bus_byte  = CMD_CLEAR;
                x.wait_time = WAIT_LONG;
            end
            KIND_SETPOS:
            begin
                x.bus_byte = job.addr;
            end
            KIND_DIRECT:
            begin
                x.bus_byte = job.new_char;
                x.is_data  = 1'b1;
            end
            KIND_LINE2:
            begin
                x.last = (step == 3'd1);
                if (step == 3'd0)
                begin
                    x.bus_byte = LINE2_BASE + job.addr;
                end
                else
                begin
                    x.bus_byte = job.new_char;
                    x.is_data  = 1'b1;
                end
            end
            KIND_SCROLL:
            begin
                x.last = (step == 3'd4);
                unique case (step)
                    3'd0:    x.bus_byte = LINE1_BASE + job.addr;
                    3'd1:
                    begin
                        x.bus_byte = job.old_char;
                        x.is_data  = 1'b1;
                    end
                    3'd2:    x.bus_byte = CMD_SHIFT;
                    3'd3:    x.bus_byte = LINE2_BASE + job.addr;
                    default:
                    begin
                        x.bus_byte = job.new_char;
                        x.is_data  = 1'b1;
                    end
                endcase
            end
            default:
            begin
                x.bus_byte = CMD_CLEAR;
            end
        endcase
        return x;
    endfunction

endpackage

// ===== hw/rtl/lcdseq_front.sv =====
// ----------------------------------------------------------------------------
// lcdseq_front
// accepts display requests, tracks string position and history, builds jobs
// ----------------------------------------------------------------------------
module lcdseq_front #(
    parameter int LINE_WIDTH = lcdseq_pkg::LINE_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [7:0]        char_code,
    input  logic              first_of_string,
    input  logic [1:0]        line,
    input  logic [6:0]        column,
    input  logic              q_full,
    output logic              q_push,
    output lcdseq_pkg::job_t  q_job
);
    import lcdseq_pkg::*;

    localparam logic [7:0] LW8  = 8'(LINE_WIDTH);
    localparam logic [7:0] LW28 = 8'(2 * LINE_WIDTH);

    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic       scroll_reg;
    logic       scroll_next;
    logic [7:0] hist_reg [LINE_WIDTH];

    logic       accept;
    logic       is_char;
    logic [7:0] idx;
    logic       scroll_now;
    logic       line_ok;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_char  = (action == ACT_CHAR);
    assign line_ok  = (line == 2'd1) || (line == 2'd2);

    always_comb
    begin
        idx         = first_of_string ? 8'd0 : count_reg;
        scroll_now  = (!first_of_string && scroll_reg) || (idx >= LW28);
        count_next  = idx + 8'd1;
        scroll_next = scroll_now;

        q_job.old_char = hist_reg[0];
        q_job.new_char = char_code;
        q_job.addr     = idx - LW8;
        q_job.kind     = KIND_CLEAR;
        q_push         = accept;
        unique case (action)
            ACT_INIT:   q_job.kind = KIND_INIT;
            ACT_CLEAR:  q_job.kind = KIND_CLEAR;
            ACT_SETPOS:
            begin
                q_job.kind = KIND_SETPOS;
                q_job.addr = ((line == 2'd1) ? LINE1_BASE : LINE2_BASE)
                             + {1'b0, column} - 8'd1;
                q_push     = accept && line_ok;
            end
            default:
            begin
                priority if (scroll_now)
                    q_job.kind = KIND_SCROLL;
                else if (idx >= LW8)
                    q_job.kind = KIND_LINE2;
                else
                    q_job.kind = KIND_DIRECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 8'd0;
            scroll_reg <= 1'b0;
        end
        else if (accept && is_char)
        begin
            count_reg  <= count_next;
            scroll_reg <= scroll_next;
        end
    end

    // history shift line, oldest at entry 0
    always_ff @(posedge clk)
    begin
        if (accept && is_char)
        begin
            for (int k = 0; k < LINE_WIDTH - 1; k++)
            begin
                hist_reg[k] <= hist_reg[k + 1];
            end
            hist_reg[LINE_WIDTH - 1] <= char_code;
        end
    end

    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_char && first_of_string) |=> (count_reg == 8'd1))
        else $error("string restart did not reset the character count");

endmodule

// ===== hw/rtl/lcdseq_queue.sv =====
// ----------------------------------------------------------------------------
// lcdseq_queue
// small job queue between the front and back parts
// ----------------------------------------------------------------------------
module lcdseq_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lcdseq_pkg::job_t  push_job,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output lcdseq_pkg::job_t  head_job
);
    import lcdseq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   fill_reg;
    logic [PW:0]   fill_next;

    assign full       = (fill_reg == (PW + 1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("job queue read while empty");

endmodule

// ===== hw/rtl/lcdseq_back.sv =====
// ----------------------------------------------------------------------------
// lcdseq_back
// expands queued jobs into bus transfers, one per cycle unless stalled, into an output stage
// ----------------------------------------------------------------------------
module lcdseq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  lcdseq_pkg::job_t  head_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        bus_byte,
    output logic              is_data,
    output logic [10:0]       wait_time,
    output logic              last
);
    import lcdseq_pkg::*;

    logic [2:0] step_reg;
    logic       out_valid_reg;
    xfer_t      xfer_reg;
    xfer_t      xfer_next;
    logic       load;

    assign xfer_next = make_xfer(head_job, step_reg);
    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = load && xfer_next.last;

    assign out_valid = out_valid_reg;
    assign bus_byte  = xfer_reg.bus_byte;
    assign is_data   = xfer_reg.is_data;
    assign wait_time = xfer_reg.wait_time;
    assign last      = xfer_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= xfer_next.last ? 3'd0 : step_reg + 3'd1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            xfer_reg <= xfer_next;
    end

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 3'd4)
        else $error("transfer step beyond longest job");

endmodule

// ===== hw/rtl/char_lcd_command_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// char_lcd_command_sequencer_top
// turns display requests into character-lcd bus transfers
// ----------------------------------------------------------------------------
// path: with the queue empty, a request's job is written into the queue at the
//   accepting edge, and its first transfer is then loaded into the registered
//   output stage when that stage is empty or not stalled
// throughput: one transfer per cycle from the back sequencer while the output is
//   not stalled, and a request makes 0 to 5 transfers: init 4, clear/set position/
//   early char 1, line-2 char 2, scrolling char 5, set position on a bad line none
// reset: string count, scroll flag, job queue and output valid clear at once;
//   the character history is not reset and holds nothing until written
module char_lcd_command_sequencer_top #(
    parameter int LINE_WIDTH = lcdseq_pkg::LINE_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  char_code,
    input  logic        first_of_string,
    input  logic [1:0]  line,
    input  logic [6:0]  column,
    // transfer channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  bus_byte,
    output logic        is_data,
    output logic [10:0] wait_time,
    output logic        last
);
    import lcdseq_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_head_valid;
    job_t q_push_job;
    job_t q_head_job;

    // front: takes requests while the queue has room, keeps string state
    lcdseq_front #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .char_code       (char_code),
        .first_of_string (first_of_string),
        .line            (line),
        .column          (column),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_job           (q_push_job)
    );

    // queue: lets the front run ahead while the back is stalled
    lcdseq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // back: walks each job's transfers into the registered output stage
    lcdseq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bus_byte   (bus_byte),
        .is_data    (is_data),
        .wait_time  (wait_time),
        .last       (last)
    );

endmodule
